// ===== rtl/mtp_pkg.sv =====
`default_nettype none
package mtp_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned ADDR_W        = $clog2(STATE_WORDS);
  localparam int unsigned IDX_W         = $clog2(STATE_WORDS + 1);

  localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [31:0] RESET_SEED = 32'd5489;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);
  localparam idx_t  IDX_FULL  = idx_t'(STATE_WORDS);

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_MUL,
    ALU_TWIST,
    ALU_TEMPER
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } alu_req_t;

  typedef struct packed {
    logic        we;
    addr_t       waddr;
    logic [31:0] wdata;
    addr_t       raddr_a;
    addr_t       raddr_b;
  } mem_req_t;

  function automatic addr_t next_addr(input addr_t k);
    addr_t r;
    if (k == LAST_ADDR) begin
      r = '0;
    end else begin
      r = k + addr_t'(1);
    end
    return r;
  endfunction

  function automatic addr_t mid_addr(input addr_t k);
    logic [ADDR_W:0] s;
    s = {1'b0, k} + (ADDR_W+1)'(MIDDLE_OFFSET);
    if (s >= (ADDR_W+1)'(STATE_WORDS)) begin
      s = s - (ADDR_W+1)'(STATE_WORDS);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mersenne_twister_prng.sv =====
`default_nettype none
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | command_i, seed_value_i
// out     | output    | out_valid_o / out_ready_i  | random_word_o
// cfg     | input     | cfg_valid_i / cfg_ready_o  | default_seed_i
//
// Draw with words left: read, temper, output register. Draw that rolls over the state:
// twist of every word, paced by the single write port of the state memory. Reseed: every
// word, paced by the registered multiply in the shared unit; an unseeded draw adds both.
// Reset resets control, the seeded flag and the default seed, never the state memory.
// A finished word holds in the output register while the next item is taken.
module mersenne_twister_prng
  import mtp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [31:0] seed_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] random_word_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] default_seed_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SINIT = 4'd1;
  localparam logic [3:0] S_SMUL  = 4'd2;
  localparam logic [3:0] S_SWR   = 4'd3;
  localparam logic [3:0] S_TPRE  = 4'd4;
  localparam logic [3:0] S_TCUR  = 4'd5;
  localparam logic [3:0] S_TCMP  = 4'd6;
  localparam logic [3:0] S_TWR   = 4'd7;
  localparam logic [3:0] S_DRD   = 4'd8;
  localparam logic [3:0] S_DTMP  = 4'd9;
  localparam logic [3:0] S_DOUT  = 4'd10;

  logic [3:0]  state_d, state_q;
  logic [31:0] dflt_seed_d, dflt_seed_q;
  logic        seeded_d, seeded_q;
  idx_t        idx_d, idx_q;
  addr_t       k_d, k_q;
  logic        draw_d, draw_q;
  logic [31:0] seed_d, seed_q;
  logic [31:0] cur_d, cur_q;
  logic        out_valid_d, out_valid_q;
  logic [31:0] word_d, word_q;

  mem_req_t    mem_req;
  alu_req_t    alu_req;
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic [31:0] alu_res;
  logic [31:0] seed_word;
  logic        in_xfer;
  addr_t       k_next;

  mtp_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  mtp_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;
  assign in_xfer       = in_valid_i && in_ready_o;
  assign seed_word     = alu_res + {{(32-ADDR_W){1'b0}}, k_q};
  assign k_next        = k_q + addr_t'(1);

  always_comb begin
    state_d     = state_q;
    dflt_seed_d = dflt_seed_q;
    seeded_d    = seeded_q;
    idx_d       = idx_q;
    k_d         = k_q;
    draw_d      = draw_q;
    seed_d      = seed_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    word_d      = word_q;

    mem_req.we      = 1'b0;
    mem_req.waddr   = k_q;
    mem_req.wdata   = alu_res;
    mem_req.raddr_a = k_q;
    mem_req.raddr_b = k_q;

    alu_req.op = ALU_HOLD;
    alu_req.a  = cur_q;
    alu_req.b  = rd_a;
    alu_req.c  = rd_b;

    if (cfg_valid_i && cfg_ready_o) begin
      dflt_seed_d = default_seed_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (command_i == CMD_SEED) begin
            seed_d  = seed_value_i;
            draw_d  = 1'b0;
            state_d = S_SINIT;
          end else if (!seeded_q) begin
            seed_d  = dflt_seed_q;
            draw_d  = 1'b1;
            state_d = S_SINIT;
          end else if (idx_q == IDX_FULL) begin
            state_d = S_TPRE;
          end else begin
            state_d = S_DRD;
          end
        end
      end
      S_SINIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        mem_req.wdata = seed_q;
        cur_d         = seed_q;
        k_d           = addr_t'(1);
        state_d       = S_SMUL;
      end
      S_SMUL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = cur_q;
        state_d    = S_SWR;
      end
      S_SWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k_q;
        mem_req.wdata = seed_word;
        cur_d         = seed_word;
        if (k_q == LAST_ADDR) begin
          seeded_d = 1'b1;
          idx_d    = IDX_FULL;
          state_d  = draw_q ? S_TPRE : S_IDLE;
        end else begin
          k_d     = k_next;
          state_d = S_SMUL;
        end
      end
      S_TPRE: begin
        mem_req.raddr_a = '0;
        k_d             = '0;
        state_d         = S_TCUR;
      end
      S_TCUR: begin
        cur_d           = rd_a;
        mem_req.raddr_a = next_addr(k_q);
        mem_req.raddr_b = mid_addr(k_q);
        state_d         = S_TCMP;
      end
      S_TCMP: begin
        alu_req.op = ALU_TWIST;
        alu_req.a  = cur_q;
        alu_req.b  = rd_a;
        alu_req.c  = rd_b;
        cur_d      = rd_a;
        state_d    = S_TWR;
      end
      S_TWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k_q;
        mem_req.wdata = alu_res;
        if (k_q == LAST_ADDR) begin
          idx_d   = '0;
          state_d = S_DRD;
        end else begin
          mem_req.raddr_a = next_addr(k_next);
          mem_req.raddr_b = mid_addr(k_next);
          k_d             = k_next;
          state_d         = S_TCMP;
        end
      end
      S_DRD: begin
        mem_req.raddr_a = idx_q[ADDR_W-1:0];
        state_d         = S_DTMP;
      end
      S_DTMP: begin
        alu_req.op = ALU_TEMPER;
        alu_req.a  = rd_a;
        state_d    = S_DOUT;
      end
      S_DOUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          word_d      = alu_res;
          idx_d       = idx_q + idx_t'(1);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dflt_seed_q <= RESET_SEED;
      seeded_q    <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      draw_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dflt_seed_q <= dflt_seed_d;
      seeded_q    <= seeded_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      draw_q      <= draw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
    cur_q  <= cur_d;
    word_q <= word_d;
  end

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_req.we)
    else $error("state memory written while idle");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_FULL)
    else $error("word index beyond the state");

  a_draw_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRD) |-> (seeded_q && (idx_q < IDX_FULL)))
    else $error("draw read with no tempered word available");

  a_unseeded_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (command_i == CMD_DRAW) && !seeded_q) |=> (state_q == S_SINIT))
    else $error("unseeded draw did not start seeding");

endmodule
`default_nettype wire

// ===== rtl/mtp_ram.sv =====
`default_nettype none
module mtp_ram
  import mtp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire mem_req_t    req_i,
  output logic      [31:0] rdata_a_o,
  output logic      [31:0] rdata_b_o
);

  logic [31:0] mem [STATE_WORDS];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q <= mem[req_i.raddr_a];
    rdata_b_q <= mem[req_i.raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

// ===== rtl/mtp_alu.sv =====
`default_nettype none
module mtp_alu
  import mtp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire alu_req_t    req_i,
  output logic      [31:0] res_o
);

  logic [31:0] res_d;
  logic [31:0] res_q;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] t;

  always_comb begin
    res_d = res_q;
    x     = req_i.a ^ (req_i.a >> 30);
    y     = (req_i.a & HIGH_BIT) | (req_i.b & LOW_BITS);
    t     = req_i.a ^ (req_i.a >> 11);
    t     = t ^ ((t << 7) & TEMPER_B);
    t     = t ^ ((t << 15) & TEMPER_C);
    t     = t ^ (t >> 18);
    case (req_i.op)
      ALU_HOLD:   res_d = res_q;
      ALU_MUL:    res_d = x * INIT_MULT;
      ALU_TWIST:  res_d = req_i.c ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
      ALU_TEMPER: res_d = t;
      default:    res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import mtp_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 1400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] seed;
  } gen_req_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        command    = CMD_DRAW;
  logic [31:0] seed_value = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [31:0] random_word;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_seed   = '0;

  gen_req_t    pending_reqs[$];
  logic [31:0] expected_words[$];
  bit          no_idle     = 1'b0;
  int unsigned fail_count  = 0;
  int unsigned in_gap      = 0;
  int unsigned out_stall   = 0;
  int unsigned idle_cycles = 0;
  gen_req_t    req;
  logic [31:0] want;

  logic [31:0] mt_words[STATE_WORDS];
  int unsigned mt_pos          = 0;
  bit          mt_seeded       = 1'b0;
  logic [31:0] mt_default_seed = RESET_SEED;

  always #5 clk_i = ~clk_i;

  mersenne_twister_prng DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .seed_value_i   (seed_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .random_word_o  (random_word),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .default_seed_i (cfg_seed)
  );

  function automatic void mt_load(input logic [31:0] s);
    int i;
    mt_words[0] = s;
    for (i = 1; i < STATE_WORDS; i++) begin
      mt_words[i] = INIT_MULT * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + 32'(i);
    end
    mt_pos    = STATE_WORDS;
    mt_seeded = 1'b1;
  endfunction

  function automatic void mt_twist();
    int          k;
    logic [31:0] y;
    logic [31:0] v;
    for (k = 0; k < STATE_WORDS; k++) begin
      y = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LOW_BITS);
      v = mt_words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TWIST_XOR;
      end
      mt_words[k] = v;
    end
    mt_pos = 0;
  endfunction

  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void mt_apply(input logic cmd, input logic [31:0] seed);
    if (cmd == CMD_SEED) begin
      mt_load(seed);
    end else begin
      if (!mt_seeded) begin
        mt_load(mt_default_seed);
      end
      if (mt_pos >= STATE_WORDS) begin
        mt_twist();
      end
      expected_words.push_back(mt_temper(mt_words[mt_pos]));
      mt_pos++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 16);
    end
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [31:0] rand_seed();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 32'h0000_0000;
    end else if (r == 1) begin
      return 32'hffff_ffff;
    end
    return $urandom;
  endfunction

  task automatic push_req(input logic cmd, input logic [31:0] seed);
    gen_req_t r;
    r.cmd  = cmd;
    r.seed = seed;
    pending_reqs.push_back(r);
  endtask

  task automatic push_draws(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      push_req(CMD_DRAW, $urandom);
    end
  endtask

  task automatic cfg_write(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_seed  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mt_default_seed = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        mt_apply(command, seed_value);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0 || pending_reqs.size() == 0) begin
          if (in_gap != 0) begin
            in_gap--;
          end
          in_valid <= 1'b0;
        end else begin
          req = pending_reqs.pop_front();
          in_valid   <= 1'b1;
          command    <= req.cmd;
          seed_value <= req.seed;
          in_gap = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: random_word expected none actual %h", $time, random_word);
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want) begin
            fail_count++;
            $display("%0t: random_word expected %h actual %h", $time, want, random_word);
          end
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_stall = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    case ($urandom_range(0, 3))
      1: cfg_write(32'h0000_0000);
      2: cfg_write(32'hffff_ffff);
      3: cfg_write($urandom);
      default: ;
    endcase

    // first draw seeds from the register
    push_draws(4);
    push_req(CMD_SEED, 32'h0000_0000);
    push_draws(2);
    push_req(CMD_SEED, 32'hffff_ffff);
    push_draws(2);
    push_req(CMD_SEED, $urandom);
    push_req(CMD_SEED, 32'h0000_0001);
    push_draws(1);
    push_req(CMD_SEED, 32'h8000_0000);
    push_req(CMD_DRAW, 32'hffff_ffff);
    push_req(CMD_DRAW, 32'h0000_0000);
    push_req(CMD_SEED, RESET_SEED);
    push_draws(3);
    wait_drained();
    cfg_write(32'h0000_0000);

    // run past the end of the state into a second twist
    push_req(CMD_SEED, rand_seed());
    push_draws(700);
    wait_drained();
    cfg_write(32'hffff_ffff);

    for (p = 0; p < 2; p++) begin
      if (p != 0) begin
        cfg_write($urandom);
      end
      no_idle = (p == 1);
      n = 0;
      while (n < 215) begin
        push_req(CMD_SEED, rand_seed());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
        push_draws(len);
        n += 1 + len;
        if ($urandom_range(0, 5) == 0) begin
          push_req(CMD_SEED, rand_seed());
          n++;
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
